// ===== hdl/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants of the countdown timer with warning blink.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int REM_W    = 26;   // remaining time in ms
    localparam int TOTAL_W  = 16;   // countdown length in s
    localparam int WARN_W   = 22;   // warning threshold in ms
    localparam int ELAPSED_W = 16;
    localparam int ACTION_W = 3;
    localparam int STATE_W  = 2;
    localparam int COLOR_W  = 2;
    localparam int PHASE_W  = 10;   // ms within one second
    localparam int QUOT_W   = 17;   // remaining / 1000

    localparam logic [REM_W-1:0]   NEAR_ZERO_MS  = REM_W'(100);
    localparam logic [PHASE_W-1:0] MS_PER_S      = PHASE_W'(1000);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET_S = TOTAL_W'(25 * 60);
    localparam logic [WARN_W-1:0]  WARN_RESET_MS = WARN_W'(60000);
    localparam logic [REM_W-1:0]   FULL_RESET_MS = REM_W'(25 * 60 * 1000);

    // blink windows inside one second
    localparam logic [PHASE_W-1:0] QTR_PERIOD = PHASE_W'(250);
    localparam logic [PHASE_W-1:0] QTR_ON     = PHASE_W'(200);
    localparam logic [PHASE_W-1:0] HALF_PERIOD = PHASE_W'(500);
    localparam logic [PHASE_W-1:0] HALF_ON    = PHASE_W'(400);
    localparam logic [PHASE_W-1:0] FULL_ON    = PHASE_W'(800);

    // reciprocal of 1000 for the phase divider
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 1000);

    typedef enum logic [STATE_W-1:0] {
        ST_WAITING = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PAUSED  = 2'd2,
        ST_STOPPED = 2'd3
    } run_state_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_PAUSE = 3'd2,
        ACT_RESET = 3'd3,
        ACT_STOP  = 3'd4
    } action_t;

    typedef enum logic [COLOR_W-1:0] {
        CLR_NORMAL  = 2'd0,
        CLR_BLINK   = 2'd1,
        CLR_IDLE    = 2'd2,
        CLR_STOPPED = 2'd3
    } color_t;

    typedef enum logic {
        CFG_TOTAL = 1'b0,
        CFG_WARN  = 1'b1
    } cfg_index_t;

    // timer status after one beat
    typedef struct packed {
        run_state_t       st;
        logic [REM_W-1:0] rem;
        logic             fin;
    } cdt_status_t;

endpackage

// ===== hdl/countdown_timer_with_warning_blink.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_with_warning_blink
// Millisecond countdown timer with pause, stop and a blinking warning class.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one beat is a tick or a command. s_tuser carries the action
//   (tick, start, pause toggle, reset, stop), s_tdata the elapsed ms of a tick.
//   m_ channel: one beat per input beat, in order. m_tdata carries run state,
//   remaining ms and color class; m_tlast marks the tick that ended the count.
//   cfg_ port: total_seconds (index 0) and warn_ms (index 1), written while
//   idle; a new length is used on the next start or reset.
// timing
//   state update happens at the accepting edge; the color class runs through
//   a reciprocal multiply by 1/1000 and a remainder stage, so a result passes
//   state, divide and output registers. one beat per cycle unless m_tready stalls.
// reset
//   aresetn low: state waiting, remaining 1500 s, registers at defaults,
//   pipeline empty.
// stall
//   when m_tready is low the output beat holds; upstream stages keep filling
//   bubbles, and s_tready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module countdown_timer_with_warning_blink
    import cdt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] elapsed_ms
    input  logic [7:0]          s_tuser,   // [2:0] action
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [1:0] run_state_out, [27:2] remaining_out,
                                           // [29:28] color_class
    output logic                m_tlast,   // finished
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [WARN_W-1:0]   cfg_wdata
);

    // configuration registers; full length kept in ms so start is a plain load
    logic [REM_W-1:0]  full_ms_reg;
    logic [WARN_W-1:0] warn_reg;
    logic [REM_W-1:0]  full_ms_next;

    assign full_ms_next = REM_W'(cfg_wdata[TOTAL_W-1:0]) * REM_W'(MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_ms_reg <= FULL_RESET_MS;
            warn_reg    <= WARN_RESET_MS;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TOTAL: full_ms_reg <= full_ms_next;
                CFG_WARN:  warn_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // pipeline occupancy: state stage, divide stage, output stage
    logic v_st_reg, v_div_reg, v_out_reg;
    logic adv_st, adv_div, adv_out;
    logic accept;

    assign adv_out = !v_out_reg || m_tready;
    assign adv_div = !v_div_reg || adv_out;
    assign adv_st  = !v_st_reg  || adv_div;
    assign s_tready = adv_st;
    assign accept   = s_tvalid && adv_st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_st_reg  <= 1'b0;
            v_div_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end else begin
            if (accept)       v_st_reg <= 1'b1;
            else if (adv_div) v_st_reg <= 1'b0;
            if (adv_div) v_div_reg <= v_st_reg;
            if (adv_out) v_out_reg <= v_div_reg;
        end
    end

    // timer state; its registers double as the first pipeline stage
    cdt_status_t status_st, status_out;
    logic [COLOR_W-1:0] color;

    cdt_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (s_tuser[ACTION_W-1:0]),
        .elapsed_ms (s_tdata[ELAPSED_W-1:0]),
        .full_ms    (full_ms_reg),
        .status     (status_st)
    );

    // color class, two registered stages
    cdt_color u_color (
        .aclk       (aclk),
        .en_div     (adv_div),
        .en_out     (adv_out),
        .status_in  (status_st),
        .warn_ms    (warn_reg),
        .status_out (status_out),
        .color      (color)
    );

    assign m_tvalid = v_out_reg;
    assign m_tdata  = {2'b00, color, status_out.rem, status_out.st};
    assign m_tlast  = status_out.fin;

endmodule

// ===== hdl/cdt_state.sv =====
// ----------------------------------------------------------------------------
// cdt_state
// Run state and remaining time, updated once per accepted beat.
// ----------------------------------------------------------------------------
module cdt_state
    import cdt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [ACTION_W-1:0]  action,
    input  logic [ELAPSED_W-1:0] elapsed_ms,
    input  logic [REM_W-1:0]     full_ms,
    output cdt_status_t          status
);

    run_state_t       st_reg, st_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             fin_reg, fin_next;
    logic [REM_W-1:0] rem_dec;

    assign rem_dec = (rem_reg > REM_W'(elapsed_ms)) ? rem_reg - REM_W'(elapsed_ms) : '0;

    always_comb begin
        st_next  = st_reg;
        rem_next = rem_reg;
        fin_next = 1'b0;
        unique case (action_t'(action))
            ACT_TICK: begin
                if (st_reg == ST_RUNNING) begin
                    rem_next = rem_dec;
                    if (rem_dec <= NEAR_ZERO_MS) begin
                        st_next  = ST_STOPPED;
                        fin_next = 1'b1;
                    end
                end
            end
            ACT_START: begin
                rem_next = full_ms;
                st_next  = ST_RUNNING;
            end
            ACT_PAUSE: begin
                if (st_reg == ST_RUNNING) st_next = ST_PAUSED;
                else if (st_reg == ST_PAUSED) st_next = ST_RUNNING;
            end
            ACT_RESET: begin
                rem_next = full_ms;
                st_next  = ST_WAITING;
            end
            ACT_STOP: begin
                if (st_reg == ST_RUNNING || st_reg == ST_PAUSED) st_next = ST_STOPPED;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_WAITING;
            rem_reg <= FULL_RESET_MS;
            fin_reg <= 1'b0;
        end else if (accept) begin
            st_reg  <= st_next;
            rem_reg <= rem_next;
            fin_reg <= fin_next;
        end
    end

    assign status.st  = st_reg;
    assign status.rem = rem_reg;
    assign status.fin = fin_reg;

endmodule

// ===== hdl/cdt_color.sv =====
// ----------------------------------------------------------------------------
// cdt_color
// Two-stage color classifier: divide by 1000, then blink window compare.
// ----------------------------------------------------------------------------
module cdt_color
    import cdt_pkg::*;
(
    input  logic              aclk,
    input  logic              en_div,
    input  logic              en_out,
    input  cdt_status_t       status_in,
    input  logic [WARN_W-1:0] warn_ms,
    output cdt_status_t       status_out,
    output logic [COLOR_W-1:0] color
);

    localparam int PROD_W = REM_W + RECIP_W;

    // stage: reciprocal multiply and threshold compares
    logic [REM_W-1:0]  rsub;
    logic [PROD_W-1:0] prod;
    logic [WARN_W:0]   thr_qtr, thr_half, thr_full;

    assign rsub = (status_in.rem > NEAR_ZERO_MS) ? status_in.rem - NEAR_ZERO_MS : '0;
    assign prod = PROD_W'(rsub) * PROD_W'(RECIP_1000);
    assign thr_qtr  = (WARN_W+1)'(warn_ms >> 2) + (WARN_W+1)'(NEAR_ZERO_MS);
    assign thr_half = (WARN_W+1)'(warn_ms >> 1) + (WARN_W+1)'(NEAR_ZERO_MS);
    assign thr_full = (WARN_W+1)'(warn_ms) + (WARN_W+1)'(NEAR_ZERO_MS);

    cdt_status_t       stat_d_reg;
    logic [REM_W-1:0]  rsub_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              in_qtr_reg, in_half_reg, in_full_reg;

    always_ff @(posedge aclk) begin
        if (en_div) begin
            stat_d_reg  <= status_in;
            rsub_reg    <= rsub;
            quot_reg    <= prod[RECIP_SHIFT +: QUOT_W];
            in_qtr_reg  <= REM_W'(thr_qtr)  >= status_in.rem;
            in_half_reg <= REM_W'(thr_half) >= status_in.rem;
            in_full_reg <= REM_W'(thr_full) >= status_in.rem;
        end
    end

    // stage: remainder with one correction step, then blink windows
    logic [REM_W:0]    qk;
    logic [REM_W:0]    rdiff;
    logic [PHASE_W:0]  rnd;
    logic [PHASE_W-1:0] m;
    logic              blink_qtr, blink_half, blink_full;
    color_t            color_next;

    assign qk    = (REM_W+1)'(quot_reg) * (REM_W+1)'(MS_PER_S);
    assign rdiff = (REM_W+1)'(rsub_reg) - qk;
    assign rnd   = rdiff[PHASE_W:0];
    assign m     = (rnd >= (PHASE_W+1)'(MS_PER_S)) ? PHASE_W'(rnd - (PHASE_W+1)'(MS_PER_S))
                                                   : PHASE_W'(rnd);

    assign blink_qtr  = (m >= QTR_ON && m < QTR_PERIOD)
                     || (m >= QTR_PERIOD + QTR_ON && m < PHASE_W'(2 * QTR_PERIOD))
                     || (m >= PHASE_W'(2 * QTR_PERIOD + QTR_ON)
                         && m < PHASE_W'(3 * QTR_PERIOD))
                     || (m >= PHASE_W'(3 * QTR_PERIOD + QTR_ON));
    assign blink_half = (m >= HALF_ON && m < HALF_PERIOD) || (m >= HALF_PERIOD + HALF_ON);
    assign blink_full = (m >= FULL_ON);

    always_comb begin
        if (stat_d_reg.st == ST_STOPPED)      color_next = CLR_STOPPED;
        else if (stat_d_reg.st != ST_RUNNING) color_next = CLR_IDLE;
        else if (in_qtr_reg)                  color_next = blink_qtr  ? CLR_BLINK : CLR_NORMAL;
        else if (in_half_reg)                 color_next = blink_half ? CLR_BLINK : CLR_NORMAL;
        else if (in_full_reg)                 color_next = blink_full ? CLR_BLINK : CLR_NORMAL;
        else                                  color_next = CLR_NORMAL;
    end

    cdt_status_t stat_o_reg;
    color_t      color_reg;

    always_ff @(posedge aclk) begin
        if (en_out) begin
            stat_o_reg <= stat_d_reg;
            color_reg  <= color_next;
        end
    end

    assign status_out = stat_o_reg;
    assign color      = color_reg;

endmodule
